// ===== sv/ttb_pkg.sv =====
`timescale 1ns / 1ps

package ttb_pkg;

  // Default grid size
  localparam int MAX_COLUMNS_DEF = 64;
  localparam int MAX_ROWS_DEF    = 16;

  // Field widths
  localparam int CMD_W        = 3;
  localparam int CHAR_W       = 8;
  localparam int COORD_W      = 8;
  localparam int CURSOR_COL_W = 6;
  localparam int CURSOR_ROW_W = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int COLS_W     = 7;
  localparam int ROWS_W     = 5;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'b1;

  localparam logic [COLS_W-1:0] COLS_RESET = 7'd16;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 5'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] BLANK   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] RETURN  = 8'h0D;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 3'd0,
    CMD_GOTO  = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_READ  = 3'd3,
    CMD_ACK   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_DRAIN,
    ST_PUT,
    ST_CLEAR,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [CHAR_W-1:0]       cell_char;
    logic [CURSOR_COL_W-1:0] cursor_col;
    logic [CURSOR_ROW_W-1:0] cursor_row;
    logic                    buffer_changed;
    logic                    scroll_waiting;
  } rsp_t;

endpackage

// ===== sv/ttb_ifs.sv =====
`timescale 1ns / 1ps

interface ttb_req_if;
  logic                          valid;
  logic                          ready;
  logic [ttb_pkg::CMD_W-1:0]     cmd;
  logic [ttb_pkg::CHAR_W-1:0]    char_code;
  logic [ttb_pkg::COORD_W-1:0]   target_col;
  logic [ttb_pkg::COORD_W-1:0]   target_row;

  modport source (output valid, cmd, char_code, target_col, target_row, input ready);
  modport sink   (input valid, cmd, char_code, target_col, target_row, output ready);
endinterface

interface ttb_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ttb_pkg::CHAR_W-1:0]        cell_char;
  logic [ttb_pkg::CURSOR_COL_W-1:0]  cursor_col;
  logic [ttb_pkg::CURSOR_ROW_W-1:0]  cursor_row;
  logic                              buffer_changed;
  logic                              scroll_waiting;

  modport source (output valid, cell_char, cursor_col, cursor_row, buffer_changed,
                  scroll_waiting, input ready);
  modport sink   (input valid, cell_char, cursor_col, cursor_row, buffer_changed,
                  scroll_waiting, output ready);
endinterface

// ===== sv/ttb_ram.sv =====
`timescale 1ns / 1ps

module ttb_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ttb_rsp_fifo.sv =====
`timescale 1ns / 1ps

// Two-entry result queue: two entries used in turn by a write and a read pointer.
module ttb_rsp_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ttb_pkg::rsp_t     push_data,
  output logic              room,
  ttb_rsp_if.source         rsp
);

  ttb_pkg::rsp_t ent [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          pop;

  assign pop  = rsp.valid && rsp.ready;
  assign room = (count != 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_data;
    end
  end

  assign rsp.valid          = (count != 2'd0);
  assign rsp.cell_char      = ent[rd_ptr].cell_char;
  assign rsp.cursor_col     = ent[rd_ptr].cursor_col;
  assign rsp.cursor_row     = ent[rd_ptr].cursor_row;
  assign rsp.buffer_changed = ent[rd_ptr].buffer_changed;
  assign rsp.scroll_waiting = ent[rd_ptr].scroll_waiting;

endmodule

// ===== sv/text_terminal_buffer_top.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// req       in   valid/ready    cmd, char_code, target_col, target_row
// rsp       out  valid/ready    cell_char, cursor_col, cursor_row, buffer_changed,
//                               scroll_waiting
// cfg       in   cfg_wen only   cfg_index, cfg_data
//
// Put (no pending scroll), newline, return, goto, acknowledge: handled directly from idle.
// Read cell: a registered read of the character RAM, through the read state.
// Put with a pending scroll: a sweep over effective rows * MAX_COLUMNS entries (a row
// count of 0 acts as 1), one RAM entry moved per cycle through the single
// write port, then the drain and put states. Clear: one entry blanked per cycle over
// all MAX_ROWS * MAX_COLUMNS entries. Reset: a clearing pass fills the RAM with
// spaces; req.ready stays low meanwhile, cfg writes are taken as usual.
// Stalls: results queue in a two-entry buffer, so one finished transaction may
// wait on rsp while the next is accepted.

module text_terminal_buffer_top #(
  parameter int MAX_COLUMNS = ttb_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = ttb_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  ttb_req_if.sink                           req,
  ttb_rsp_if.source                         rsp,
  input  logic                              cfg_wen,
  input  logic [ttb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ttb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;  // cursor column
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;        // cursor row
  localparam int CNW   = $clog2(MAX_COLUMNS + 1);                      // column count
  localparam int RNW   = $clog2(MAX_ROWS + 1);                         // row count

  // Out-of-range sizes: zero acts as one, above max acts as max.
  function automatic logic [CNW-1:0] eff_cols_of(input logic [ttb_pkg::COLS_W-1:0] v);
    logic [CNW-1:0] r;
    if (v == '0) r = CNW'(1);
    else if (int'(v) > MAX_COLUMNS) r = CNW'(MAX_COLUMNS);
    else r = CNW'(v);
    return r;
  endfunction

  function automatic logic [RNW-1:0] eff_rows_of(input logic [ttb_pkg::ROWS_W-1:0] v);
    logic [RNW-1:0] r;
    if (v == '0) r = RNW'(1);
    else if (int'(v) > MAX_ROWS) r = RNW'(MAX_ROWS);
    else r = RNW'(v);
    return r;
  endfunction

  // Control state
  ttb_pkg::state_t              state, state_next;
  logic [AW-1:0]                cnt, cnt_next;
  logic [CW-1:0]                cur_col, cur_col_next;
  logic [RW-1:0]                cur_row, cur_row_next;
  logic                         pend, pend_next;
  logic                         dirty, dirty_next;
  logic [ttb_pkg::COLS_W-1:0]   cols_cfg;
  logic [ttb_pkg::ROWS_W-1:0]   rows_cfg;
  logic                         wr_pend, wr_pend_next;

  // Payload registers
  logic [ttb_pkg::CHAR_W-1:0]   lat, lat_next;
  logic [AW-1:0]                wr_addr, wr_addr_next;
  logic                         wr_blank, wr_blank_next;

  // RAM port
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [ttb_pkg::CHAR_W-1:0]   ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [ttb_pkg::CHAR_W-1:0]   ram_rdata;

  // Result path
  logic                         push;
  logic                         room;
  logic [ttb_pkg::CHAR_W-1:0]   cell_next;
  ttb_pkg::rsp_t                rsp_next;

  // Derived values
  logic [CNW-1:0]               eff_cols, new_cols;
  logic [RNW-1:0]               eff_rows, new_rows;
  logic [AW:0]                  copy_len, scroll_last;
  logic [AW-1:0]                cur_addr, read_addr, scroll_raddr;
  logic [CNW-1:0]               col_inc;
  logic [RNW-1:0]               row_inc;
  logic                         wrap, row_over;
  logic [RW-1:0]                row_last;
  logic [CW-1:0]                adv_col, goto_col, read_col;
  logic [RW-1:0]                adv_row, goto_row, read_row;
  logic                         adv_pend;
  logic [ttb_pkg::CHAR_W-1:0]   code_fixed;
  logic                         accept;

  assign eff_cols = eff_cols_of(cols_cfg);
  assign eff_rows = eff_rows_of(rows_cfg);
  assign new_cols = eff_cols_of(cfg_data[ttb_pkg::COLS_W-1:0]);
  assign new_rows = eff_rows_of(cfg_data[ttb_pkg::ROWS_W-1:0]);

  // Scroll sweep: entries below copy_len take the entry one row down,
  // the rest (bottom row in use) become blank.
  assign copy_len    = (AW+1)'((int'(eff_rows) - 1) * MAX_COLUMNS);
  assign scroll_last = (AW+1)'(int'(eff_rows) * MAX_COLUMNS - 1);

  assign cur_addr     = AW'(int'(cur_row) * MAX_COLUMNS + int'(cur_col));
  assign scroll_raddr = AW'(int'(cnt) + MAX_COLUMNS);

  // Cursor advance after a stored character
  assign col_inc  = CNW'(cur_col) + 1'b1;
  assign row_inc  = RNW'(cur_row) + 1'b1;
  assign wrap     = (col_inc >= eff_cols);
  assign row_over = (row_inc >= eff_rows);
  assign row_last = RW'(eff_rows - 1'b1);
  assign adv_col  = wrap ? '0 : CW'(col_inc);
  assign adv_row  = wrap ? (row_over ? row_last : RW'(row_inc)) : cur_row;
  assign adv_pend = wrap && row_over;

  // Clamped targets for goto and read
  assign goto_col  = (int'(req.target_col) >= int'(eff_cols)) ? CW'(eff_cols - 1'b1)
                                                              : CW'(req.target_col);
  assign goto_row  = (int'(req.target_row) >= int'(eff_rows)) ? row_last
                                                              : RW'(req.target_row);
  assign read_col  = goto_col;
  assign read_row  = goto_row;
  assign read_addr = AW'(int'(read_row) * MAX_COLUMNS + int'(read_col));

  // Control codes below space print as space
  assign code_fixed = (req.char_code < ttb_pkg::BLANK) ? ttb_pkg::BLANK : req.char_code;

  // One transaction at a time; a free queue slot is reserved at acceptance.
  assign req.ready = (state == ttb_pkg::ST_IDLE) && room;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ttb_pkg::ST_INIT;
      cnt      <= '0;
      cur_col  <= '0;
      cur_row  <= '0;
      pend     <= 1'b0;
      dirty    <= 1'b1;
      cols_cfg <= ttb_pkg::COLS_RESET;
      rows_cfg <= ttb_pkg::ROWS_RESET;
      wr_pend  <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      pend    <= pend_next;
      dirty   <= dirty_next;
      wr_pend <= wr_pend_next;
      if (cfg_wen) begin
        unique case (cfg_index)
          ttb_pkg::REG_COLUMNS: cols_cfg <= cfg_data[ttb_pkg::COLS_W-1:0];
          ttb_pkg::REG_ROWS:    rows_cfg <= cfg_data[ttb_pkg::ROWS_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    lat      <= lat_next;
    wr_addr  <= wr_addr_next;
    wr_blank <= wr_blank_next;
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    cur_col_next  = cur_col;
    cur_row_next  = cur_row;
    pend_next     = pend;
    dirty_next    = dirty;
    lat_next      = lat;
    wr_pend_next  = 1'b0;
    wr_addr_next  = wr_addr;
    wr_blank_next = wr_blank;
    ram_we        = 1'b0;
    ram_waddr     = cur_addr;
    ram_wdata     = ttb_pkg::BLANK;
    ram_raddr     = scroll_raddr;
    push          = 1'b0;
    cell_next     = '0;

    unique case (state) inside
      ttb_pkg::ST_INIT, ttb_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        if (cnt == AW'(DEPTH - 1)) begin
          state_next = ttb_pkg::ST_IDLE;
          cnt_next   = '0;
          if (state == ttb_pkg::ST_CLEAR) begin
            cur_col_next = '0;
            cur_row_next = '0;
            pend_next    = 1'b0;
            dirty_next   = 1'b1;
            push         = 1'b1;
          end
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      ttb_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req.cmd)
            ttb_pkg::CMD_PUT: begin
              if (req.char_code == ttb_pkg::NEWLINE) begin
                cur_col_next = '0;
                cur_row_next = row_over ? row_last : RW'(row_inc);
                pend_next    = row_over || pend;
                push         = 1'b1;
              end else if (req.char_code == ttb_pkg::RETURN) begin
                cur_col_next = '0;
                push         = 1'b1;
              end else if (pend) begin
                // scroll first, store after
                lat_next   = code_fixed;
                cnt_next   = '0;
                state_next = ttb_pkg::ST_SCROLL;
              end else begin
                ram_we       = 1'b1;
                ram_wdata    = code_fixed;
                cur_col_next = adv_col;
                cur_row_next = adv_row;
                pend_next    = adv_pend;
                dirty_next   = 1'b1;
                push         = 1'b1;
              end
            end
            ttb_pkg::CMD_GOTO: begin
              cur_col_next = goto_col;
              cur_row_next = goto_row;
              pend_next    = 1'b0;
              push         = 1'b1;
            end
            ttb_pkg::CMD_CLEAR: begin
              cnt_next   = '0;
              state_next = ttb_pkg::ST_CLEAR;
            end
            ttb_pkg::CMD_READ: begin
              ram_raddr  = read_addr;
              state_next = ttb_pkg::ST_READ;
            end
            ttb_pkg::CMD_ACK: begin
              dirty_next = 1'b0;
              push       = 1'b1;
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end

      ttb_pkg::ST_SCROLL: begin
        // read one row ahead, write the previous cycle's entry
        ram_we        = wr_pend;
        ram_waddr     = wr_addr;
        ram_wdata     = wr_blank ? ttb_pkg::BLANK : ram_rdata;
        wr_pend_next  = 1'b1;
        wr_addr_next  = cnt;
        wr_blank_next = ({1'b0, cnt} >= copy_len);
        if ({1'b0, cnt} == scroll_last) begin
          state_next = ttb_pkg::ST_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      ttb_pkg::ST_DRAIN: begin
        ram_we     = wr_pend;
        ram_waddr  = wr_addr;
        ram_wdata  = wr_blank ? ttb_pkg::BLANK : ram_rdata;
        cnt_next   = '0;
        state_next = ttb_pkg::ST_PUT;
      end

      ttb_pkg::ST_PUT: begin
        ram_we       = 1'b1;
        ram_wdata    = lat;
        cur_col_next = adv_col;
        cur_row_next = adv_row;
        pend_next    = adv_pend;
        dirty_next   = 1'b1;
        push         = 1'b1;
        state_next   = ttb_pkg::ST_IDLE;
      end

      ttb_pkg::ST_READ: begin
        cell_next  = ram_rdata;
        push       = 1'b1;
        state_next = ttb_pkg::ST_IDLE;
      end

      default: begin
        state_next = ttb_pkg::ST_INIT;
        cnt_next   = '0;
      end
    endcase

    // Size change pulls the cursor inside the new grid
    if (cfg_wen) begin
      unique case (cfg_index)
        ttb_pkg::REG_COLUMNS: begin
          if (int'(cur_col_next) >= int'(new_cols)) cur_col_next = CW'(new_cols - 1'b1);
        end
        ttb_pkg::REG_ROWS: begin
          if (int'(cur_row_next) >= int'(new_rows)) cur_row_next = RW'(new_rows - 1'b1);
        end
      endcase
    end
  end

  always_comb begin
    rsp_next.cell_char      = cell_next;
    rsp_next.cursor_col     = ttb_pkg::CURSOR_COL_W'(cur_col_next);
    rsp_next.cursor_row     = ttb_pkg::CURSOR_ROW_W'(cur_row_next);
    rsp_next.buffer_changed = dirty_next;
    rsp_next.scroll_waiting = pend_next;
  end

  ttb_ram #(
    .WIDTH (ttb_pkg::CHAR_W),
    .DEPTH (DEPTH)
  ) u_char_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ttb_rsp_fifo u_rsp_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (rsp_next),
    .room      (room),
    .rsp       (rsp)
  );

endmodule

// ===== sv/ttb_checker.sv =====
`timescale 1ns / 1ps

module ttb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_ready,
  input logic [ttb_pkg::CMD_W-1:0]         req_cmd,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic [ttb_pkg::CHAR_W-1:0]        rsp_cell_char,
  input logic [ttb_pkg::CURSOR_COL_W-1:0]  rsp_cursor_col,
  input logic [ttb_pkg::CURSOR_ROW_W-1:0]  rsp_cursor_row,
  input logic                              rsp_buffer_changed,
  input logic                              rsp_scroll_waiting
);

  // Clearing pass after reset: nothing accepted, nothing produced.
  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !req_ready && !rsp_valid)
    else $error("activity right after reset");

  // Clear sweeps the RAM, so the input side closes at once.
  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_cmd == ttb_pkg::CMD_CLEAR |=> !req_ready)
    else $error("clear did not stall input");

  // A pending scroll always leaves the cursor at column 0.
  a_scroll_col0: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_scroll_waiting |-> rsp_cursor_col == '0)
    else $error("scroll pending with cursor off column 0");

  // Stalled result holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_char)
      && $stable(rsp_cursor_col) && $stable(rsp_cursor_row)
      && $stable(rsp_buffer_changed) && $stable(rsp_scroll_waiting))
    else $error("result changed while stalled");

endmodule

bind text_terminal_buffer_top ttb_checker u_ttb_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .req_cmd            (req.cmd),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_cell_char      (rsp.cell_char),
  .rsp_cursor_col     (rsp.cursor_col),
  .rsp_cursor_row     (rsp.cursor_row),
  .rsp_buffer_changed (rsp.buffer_changed),
  .rsp_scroll_waiting (rsp.scroll_waiting)
);

// ===== tb/text_terminal_buffer_top_tb.sv =====
`timescale 1ns / 1ps

module text_terminal_buffer_top_tb;

  // Highest value the 3-bit command field can carry; codes above CMD_ACK are unused.
  localparam int CMD_TOP = (1 << ttb_pkg::CMD_W) - 1;
  // Worst single transaction: scroll of a full 16-row grid.
  localparam int SETTLE_CYCLES = ttb_pkg::MAX_ROWS_DEF * ttb_pkg::MAX_COLUMNS_DEF + 64;

  typedef struct packed {
    logic [ttb_pkg::CMD_W-1:0]   cmd;
    logic [ttb_pkg::CHAR_W-1:0]  char_code;
    logic [ttb_pkg::COORD_W-1:0] target_col;
    logic [ttb_pkg::COORD_W-1:0] target_row;
  } term_item_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wen;
  logic [ttb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ttb_pkg::CFG_DATA_W-1:0] cfg_data;

  ttb_req_if req_ch();
  ttb_rsp_if rsp_ch();

  text_terminal_buffer_top dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Stimulus waiting for the driver, and responses the screen model predicts.
  term_item_t    cmd_queue[$];
  ttb_pkg::rsp_t want_rsp[$];
  term_item_t    held_item;
  bit            holding = 1'b0;   // driver has a transaction on the bus
  bit            steady  = 1'b0;   // no idling on either side while set
  int            fails   = 0;

  // ---------------------------------------------------------------------------
  // Screen model: character grid, cursor, deferred scroll, dirty flag and the
  // two size registers as last written.
  // ---------------------------------------------------------------------------
  logic [ttb_pkg::CHAR_W-1:0] screen [0:ttb_pkg::MAX_ROWS_DEF-1][0:ttb_pkg::MAX_COLUMNS_DEF-1];
  int                         crs_col;
  int                         crs_row;
  bit                         scroll_due;
  bit                         dirty;
  logic [ttb_pkg::COLS_W-1:0] cols_reg;
  logic [ttb_pkg::ROWS_W-1:0] rows_reg;

  // Register value 0 behaves as 1; anything above the grid behaves as the grid.
  function automatic int span_cols();
    if (cols_reg == 0) return 1;
    if (int'(cols_reg) > ttb_pkg::MAX_COLUMNS_DEF) return ttb_pkg::MAX_COLUMNS_DEF;
    return int'(cols_reg);
  endfunction

  function automatic int span_rows();
    if (rows_reg == 0) return 1;
    if (int'(rows_reg) > ttb_pkg::MAX_ROWS_DEF) return ttb_pkg::MAX_ROWS_DEF;
    return int'(rows_reg);
  endfunction

  function automatic int clip(int v, int span);
    return (v >= span) ? span - 1 : v;
  endfunction

  function automatic void blank_screen();
    for (int r = 0; r < ttb_pkg::MAX_ROWS_DEF; r++)
      for (int c = 0; c < ttb_pkg::MAX_COLUMNS_DEF; c++)
        screen[r][c] = ttb_pkg::BLANK;
  endfunction

  function automatic void screen_reset();
    blank_screen();
    crs_col    = 0;
    crs_row    = 0;
    scroll_due = 1'b0;
    dirty      = 1'b1;
    cols_reg   = ttb_pkg::COLS_RESET;
    rows_reg   = ttb_pkg::ROWS_RESET;
  endfunction

  function automatic void clip_cursor();
    crs_col = clip(crs_col, span_cols());
    crs_row = clip(crs_row, span_rows());
  endfunction

  // Rows in use move up one; the bottom row in use goes blank (full row width).
  function automatic void shift_rows();
    int rows;
    rows = span_rows();
    for (int r = 0; r + 1 < rows; r++)
      for (int c = 0; c < ttb_pkg::MAX_COLUMNS_DEF; c++)
        screen[r][c] = screen[r + 1][c];
    for (int c = 0; c < ttb_pkg::MAX_COLUMNS_DEF; c++)
      screen[rows - 1][c] = ttb_pkg::BLANK;
  endfunction

  // Applies one accepted transaction to the model and returns the response.
  function automatic ttb_pkg::rsp_t screen_step(term_item_t it);
    ttb_pkg::rsp_t res;
    int   cols;
    int   rows;
    logic [ttb_pkg::CHAR_W-1:0] code;
    cols = span_cols();
    rows = span_rows();
    res  = '0;
    clip_cursor();
    case (it.cmd)
      ttb_pkg::CMD_PUT: begin
        code = it.char_code;
        if (code == ttb_pkg::NEWLINE) begin
          crs_row++;
          crs_col = 0;
        end else if (code == ttb_pkg::RETURN) begin
          crs_col = 0;
        end else begin
          if (code < ttb_pkg::BLANK) code = ttb_pkg::BLANK;
          if (scroll_due) begin
            shift_rows();
            scroll_due = 1'b0;
          end
          screen[crs_row][crs_col] = code;
          dirty = 1'b1;
          crs_col++;
          if (crs_col >= cols) begin
            crs_col = 0;
            crs_row++;
          end
        end
        if (crs_row >= rows) begin
          scroll_due = 1'b1;
          crs_row    = rows - 1;
        end
      end
      ttb_pkg::CMD_GOTO: begin
        crs_col    = clip(int'(it.target_col), cols);
        crs_row    = clip(int'(it.target_row), rows);
        scroll_due = 1'b0;
      end
      ttb_pkg::CMD_CLEAR: begin
        blank_screen();
        dirty      = 1'b1;
        crs_col    = 0;
        crs_row    = 0;
        scroll_due = 1'b0;
      end
      ttb_pkg::CMD_READ:
        res.cell_char = screen[clip(int'(it.target_row), rows)][clip(int'(it.target_col), cols)];
      ttb_pkg::CMD_ACK:  dirty = 1'b0;
      default: ;
    endcase
    res.cursor_col     = crs_col[ttb_pkg::CURSOR_COL_W-1:0];
    res.cursor_row     = crs_row[ttb_pkg::CURSOR_ROW_W-1:0];
    res.buffer_changed = dirty;
    res.scroll_waiting = scroll_due;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: request channel. One NBA per signal per edge; valid stays high
  // until the transaction is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        want_rsp.push_back(screen_step(held_item));
        holding = 1'b0;
      end
      if (!holding) begin
        if (cmd_queue.size() > 0 && (steady || $urandom_range(99, 0) >= 34)) begin
          held_item = cmd_queue.pop_front();
          holding   = 1'b1;
          req_ch.valid      <= 1'b1;
          req_ch.cmd        <= held_item.cmd;
          req_ch.char_code  <= held_item.char_code;
          req_ch.target_col <= held_item.target_col;
          req_ch.target_row <= held_item.target_row;
        end else begin
          // idle cycle: junk payload under a low valid
          req_ch.valid      <= 1'b0;
          req_ch.cmd        <= ttb_pkg::CMD_W'($urandom);
          req_ch.char_code  <= ttb_pkg::CHAR_W'($urandom);
          req_ch.target_col <= ttb_pkg::COORD_W'($urandom);
          req_ch.target_row <= ttb_pkg::COORD_W'($urandom);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: response channel with random backpressure.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    ttb_pkg::rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (want_rsp.size() == 0) begin
          $error("response with no transaction outstanding");
          fails++;
        end else begin
          want = want_rsp.pop_front();
          if (rsp_ch.cell_char !== want.cell_char) begin
            $error("cell_char: expected %0d, got %0d", want.cell_char, rsp_ch.cell_char);
            fails++;
          end
          if (rsp_ch.cursor_col !== want.cursor_col) begin
            $error("cursor_col: expected %0d, got %0d", want.cursor_col, rsp_ch.cursor_col);
            fails++;
          end
          if (rsp_ch.cursor_row !== want.cursor_row) begin
            $error("cursor_row: expected %0d, got %0d", want.cursor_row, rsp_ch.cursor_row);
            fails++;
          end
          if (rsp_ch.buffer_changed !== want.buffer_changed) begin
            $error("buffer_changed: expected %0d, got %0d", want.buffer_changed,
                   rsp_ch.buffer_changed);
            fails++;
          end
          if (rsp_ch.scroll_waiting !== want.scroll_waiting) begin
            $error("scroll_waiting: expected %0d, got %0d", want.scroll_waiting,
                   rsp_ch.scroll_waiting);
            fails++;
          end
        end
      end
      rsp_ch.ready <= steady || $urandom_range(99, 0) >= 34;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void send(logic [ttb_pkg::CMD_W-1:0] cmd,
                               logic [ttb_pkg::CHAR_W-1:0] code,
                               logic [ttb_pkg::COORD_W-1:0] col,
                               logic [ttb_pkg::COORD_W-1:0] row);
    term_item_t it;
    it.cmd        = cmd;
    it.char_code  = code;
    it.target_col = col;
    it.target_row = row;
    cmd_queue.push_back(it);
  endfunction

  function automatic logic [ttb_pkg::CHAR_W-1:0] rnd_byte();
    return ttb_pkg::CHAR_W'($urandom);
  endfunction

  // Sender holds off until every queued transaction has been answered.
  task automatic drain();
    while (cmd_queue.size() > 0 || holding || want_rsp.size() > 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Only called with the block idle; the model follows the register write.
  task automatic write_reg(logic [ttb_pkg::CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= ttb_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx == ttb_pkg::REG_COLUMNS) cols_reg = ttb_pkg::COLS_W'(val);
    else rows_reg = ttb_pkg::ROWS_W'(val);
    clip_cursor();
  endtask

  // Mostly in-range coordinates so reads hit written cells; sometimes any byte.
  function automatic logic [ttb_pkg::COORD_W-1:0] pick_coord(int span);
    if ($urandom_range(99, 0) < 75) return ttb_pkg::COORD_W'($urandom_range(span - 1, 0));
    return ttb_pkg::COORD_W'($urandom);
  endfunction

  function automatic logic [ttb_pkg::CHAR_W-1:0] pick_char();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 60) return ttb_pkg::CHAR_W'($urandom_range(126, 32));
    if (roll < 70) return ttb_pkg::NEWLINE;
    if (roll < 75) return ttb_pkg::RETURN;
    if (roll < 85) return ttb_pkg::CHAR_W'($urandom_range(31, 0));
    return ttb_pkg::CHAR_W'($urandom_range(255, 128));
  endfunction

  // Put-heavy mix so wrap and deferred scroll get hit often; clear kept rare
  // since it costs a full pass over the RAM.
  task automatic fill_random(int count, int cols, int rows);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99, 0);
      if (roll < 66)
        send(ttb_pkg::CMD_PUT, pick_char(), rnd_byte(), rnd_byte());
      else if (roll < 76)
        send(ttb_pkg::CMD_GOTO, rnd_byte(), pick_coord(cols), pick_coord(rows));
      else if (roll < 88)
        send(ttb_pkg::CMD_READ, rnd_byte(), pick_coord(cols), pick_coord(rows));
      else if (roll < 93)
        send(ttb_pkg::CMD_ACK, rnd_byte(), rnd_byte(), rnd_byte());
      else if (roll < 96)
        send(ttb_pkg::CMD_W'($urandom_range(CMD_TOP, int'(ttb_pkg::CMD_ACK) + 1)),
             rnd_byte(), rnd_byte(), rnd_byte());
      else if (roll < 97)
        send(ttb_pkg::CMD_CLEAR, rnd_byte(), rnd_byte(), rnd_byte());
      else
        send(ttb_pkg::CMD_PUT, pick_char(), rnd_byte(), rnd_byte());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int col_set [8];
    int row_set [8];
    int eff_c;
    int eff_r;

    screen_reset();
    rst       <= 1'b1;
    cfg_wen   <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset size (16 x 2).
    send(ttb_pkg::CMD_READ, 8'h00, 8'hFF, 8'hFF);        // read clamps to last cell
    send(ttb_pkg::CMD_ACK, 8'h00, 8'h00, 8'h00);
    send(ttb_pkg::CMD_PUT, 8'h00, 8'h00, 8'h00);         // control codes print as space
    send(ttb_pkg::CMD_PUT, ttb_pkg::BLANK - 8'd1, 8'h00, 8'h00);
    send(ttb_pkg::CMD_PUT, 8'hFF, 8'hFF, 8'hFF);         // high bytes stored as is
    send(ttb_pkg::CMD_PUT, 8'h80, 8'h00, 8'h00);
    send(ttb_pkg::CMD_PUT, 8'h7E, 8'h00, 8'h00);
    send(ttb_pkg::CMD_PUT, ttb_pkg::NEWLINE, 8'h00, 8'h00);
    send(ttb_pkg::CMD_PUT, 8'h41, 8'h00, 8'h00);
    send(ttb_pkg::CMD_PUT, ttb_pkg::RETURN, 8'h00, 8'h00);
    send(ttb_pkg::CMD_GOTO, 8'h00, 8'hFF, 8'hFF);        // goto clamps
    send(ttb_pkg::CMD_PUT, 8'h5A, 8'h00, 8'h00);         // wrap off the last row -> scroll pending
    send(ttb_pkg::CMD_READ, 8'h00, 8'h0F, 8'h01);        // read leaves the scroll pending
    send(ttb_pkg::CMD_PUT, 8'h42, 8'h00, 8'h00);         // scroll happens, then the write
    send(ttb_pkg::CMD_READ, 8'h00, 8'h0F, 8'h00);
    send(ttb_pkg::CMD_PUT, ttb_pkg::NEWLINE, 8'h00, 8'h00);  // newline off the bottom
    send(ttb_pkg::CMD_GOTO, 8'h00, 8'h03, 8'h00);        // goto drops the pending scroll
    for (int c = int'(ttb_pkg::CMD_ACK) + 1; c <= CMD_TOP; c++)
      send(ttb_pkg::CMD_W'(c), 8'hFF, 8'hFF, 8'hFF);     // unused commands do nothing
    send(ttb_pkg::CMD_CLEAR, 8'h00, 8'h00, 8'h00);
    send(ttb_pkg::CMD_READ, 8'h00, 8'h0F, 8'h00);
    send(ttb_pkg::CMD_GOTO, 8'h00, 8'h0F, 8'h01);
    send(ttb_pkg::CMD_PUT, 8'h51, 8'h00, 8'h00);         // leave a scroll pending
    drain();

    // Shrink with a scroll pending: cursor clamps, pending survives; one-row scroll.
    write_reg(ttb_pkg::REG_COLUMNS, 3);
    write_reg(ttb_pkg::REG_ROWS, 1);
    send(ttb_pkg::CMD_PUT, 8'h61, 8'h00, 8'h00);
    send(ttb_pkg::CMD_PUT, 8'h62, 8'h00, 8'h00);
    send(ttb_pkg::CMD_PUT, 8'h63, 8'h00, 8'h00);
    send(ttb_pkg::CMD_PUT, 8'h64, 8'h00, 8'h00);
    send(ttb_pkg::CMD_READ, 8'h00, 8'h00, 8'h00);
    drain();

    // Random phases over a spread of sizes, zero and overrange included.
    col_set = '{0, 127, 64, 1, 64, 10, 0, 16};
    row_set = '{0, 31, 16, 16, 1, 4, 0, 2};
    col_set[6] = $urandom_range(ttb_pkg::MAX_COLUMNS_DEF, 1);
    row_set[6] = $urandom_range(ttb_pkg::MAX_ROWS_DEF, 1);
    for (int p = 0; p < 8; p++) begin
      write_reg(ttb_pkg::REG_COLUMNS, col_set[p]);
      write_reg(ttb_pkg::REG_ROWS, row_set[p]);
      eff_c  = span_cols();
      eff_r  = span_rows();
      steady = (p == 5);
      fill_random(250, eff_c, eff_r);
      drain();
    end
    steady = 1'b0;

    // Catch any stray response after the last one.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0 && want_rsp.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, sized well past the slowest legal run (every put scrolling a
  // full grid, plus random stalls on both channels).
  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
